FILE: rtl/sha_pkg.sv
package sha_pkg;

    localparam int unsigned RoundCount = 64;

    typedef logic [31:0] word_t;

    // One queued item between the intake and the core.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } item_t;

    localparam int unsigned ItemWidth = 10;
    localparam int unsigned QueueDepth = 2;

    localparam word_t [7:0] InitHash = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t [63:0] RoundK = {
        32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
        32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
        32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
        32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
        32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
        32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
        32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
        32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
        32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
        32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
        32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
        32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
        32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
        32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
        32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
        32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
    };

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenStartPos = 6'd56;

    function automatic word_t rotr(input word_t v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

endpackage

FILE: rtl/sha_front.sv
// Intake: takes beats from the stream, drops idle items that carry no end mark, and queues the rest.
module sha_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    input  logic [0:0]     s_tuser,
    input  logic           s_tlast,
    output logic           q_valid,
    input  logic           q_pop,
    output sha_pkg::item_t q_item
);

    sha_pkg::item_t slot_reg [sha_pkg::QueueDepth];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    logic           keep;

    assign s_tready = (count_reg != 2'd2);
    assign keep     = s_tuser[0] | s_tlast;
    assign push     = s_tvalid & s_tready & keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{data_byte: s_tdata, byte_valid: s_tuser[0],
                                      end_of_message: s_tlast};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

FILE: rtl/sha_core.sv
// Back end: packs bytes, pads, runs one round per cycle, holds the digest.
module sha_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_pop,
    input  sha_pkg::item_t q_item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [255:0]   m_tdata
);

    typedef enum logic [2:0] {
        ST_TAKE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_SECOND,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    sha_pkg::word_t [7:0]    hash_reg;
    sha_pkg::word_t [15:0]   w_reg;
    sha_pkg::word_t [7:0]    v_reg;
    logic [63:0]             count_reg;
    logic [5:0]              round_reg;
    logic                    final_reg;   // this compression ends the message
    logic                    second_reg;  // a block with the length follows
    logic [255:0]            out_reg;
    logic                    out_valid_reg;

    logic [5:0]              pos;
    logic [3:0]              wi;
    logic [1:0]              lane;
    sha_pkg::word_t          byte_word;
    sha_pkg::word_t          w_cur;
    sha_pkg::word_t          w_new;
    sha_pkg::word_t          s0;
    sha_pkg::word_t          s1;
    sha_pkg::word_t          t1;
    sha_pkg::word_t          t2;
    sha_pkg::word_t          ch;
    sha_pkg::word_t          maj;
    sha_pkg::word_t          sig_e;
    sha_pkg::word_t          sig_a;

    assign pos  = count_reg[8:3];
    assign wi   = pos[5:2];
    assign lane = pos[1:0];
    assign q_pop = (state_reg == ST_TAKE) & q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_comb
    begin
        byte_word = {24'd0, q_item.data_byte} << ({3'd3 - {1'b0, lane}, 3'd0});
        if (state_reg == ST_PAD)
        begin
            byte_word = {24'd0, sha_pkg::PadByte} << ({3'd3 - {1'b0, lane}, 3'd0});
        end
        s1 = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        s0 = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        w_cur = w_reg[0];
        sig_e = sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
              ^ sha_pkg::rotr(v_reg[4], 25);
        sig_a = sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
              ^ sha_pkg::rotr(v_reg[0], 22);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + sig_e + ch + sha_pkg::RoundK[round_reg] + w_cur;
        t2 = sig_a + maj;
    end

    // Window is a shift line: w_reg[0] is the current round's word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_TAKE;
            hash_reg      <= sha_pkg::InitHash;
            count_reg     <= 64'd0;
            round_reg     <= 6'd0;
            final_reg     <= 1'b0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg & m_tready & (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_TAKE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.byte_valid)
                        begin
                            if (lane == 2'd0)
                            begin
                                w_reg[wi] <= byte_word;
                            end
                            else
                            begin
                                w_reg[wi] <= w_reg[wi] | byte_word;
                            end
                            count_reg <= count_reg + 64'd8;
                        end
                        final_reg <= 1'b0;
                        if (q_item.byte_valid & (pos == 6'd63))
                        begin
                            v_reg     <= hash_reg;
                            round_reg <= 6'd0;
                            state_reg <= ST_ROUND;
                            if (q_item.end_of_message)
                            begin
                                // block full: compress it first, then a pad block
                                second_reg <= 1'b1;
                            end
                        end
                        else if (q_item.end_of_message)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    round_reg <= 6'd0;
                    v_reg     <= hash_reg;
                    for (int i = 0; i < 16; i++)
                    begin
                        if (4'(i) == wi)
                        begin
                            if (lane == 2'd0)
                            begin
                                w_reg[i] <= byte_word;
                            end
                            else
                            begin
                                w_reg[i] <= w_reg[i] | byte_word;
                            end
                        end
                        else if (4'(i) > wi)
                        begin
                            if ((pos < sha_pkg::LenStartPos) && (i == 14))
                            begin
                                w_reg[i] <= count_reg[63:32];
                            end
                            else if ((pos < sha_pkg::LenStartPos) && (i == 15))
                            begin
                                w_reg[i] <= count_reg[31:0];
                            end
                            else
                            begin
                                w_reg[i] <= '0;
                            end
                        end
                    end
                    if (pos >= sha_pkg::LenStartPos)
                    begin
                        second_reg <= 1'b1;
                        final_reg  <= 1'b0;
                    end
                    else
                    begin
                        final_reg <= 1'b1;
                    end
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    w_reg <= {w_new, w_reg[15:1]};
                    v_reg <= {v_reg[6:4], v_reg[3] + t1, v_reg[2:0], t1 + t2};
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'(sha_pkg::RoundCount - 1))
                    begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                    if (second_reg)
                    begin
                        state_reg <= ST_SECOND;
                    end
                    else if (final_reg)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_TAKE;
                    end
                end
                ST_SECOND:
                begin
                    // length block; pad byte too if pos wrapped to 0 (block full)
                    second_reg <= 1'b0;
                    round_reg  <= 6'd0;
                    v_reg      <= hash_reg;
                    for (int i = 0; i < 16; i++)
                    begin
                        if (i == 14)
                        begin
                            w_reg[i] <= count_reg[63:32];
                        end
                        else if (i == 15)
                        begin
                            w_reg[i] <= count_reg[31:0];
                        end
                        else if ((i == 0) && (pos == 6'd0))
                        begin
                            w_reg[i] <= {sha_pkg::PadByte, 24'd0};
                        end
                        else
                        begin
                            w_reg[i] <= '0;
                        end
                    end
                    final_reg <= 1'b1;
                    state_reg <= ST_ROUND;
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            out_reg[64*i +: 64] <= {hash_reg[2*i], hash_reg[2*i+1]};
                        end
                        out_valid_reg <= 1'b1;
                        hash_reg      <= sha_pkg::InitHash;
                        count_reg     <= 64'd0;
                        final_reg     <= 1'b0;
                        state_reg     <= ST_TAKE;
                    end
                end
                default:
                begin
                    state_reg <= ST_TAKE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/sha256_stream_hasher.sv
// Channel | dir | tdata                              | tuser      | tlast
// s_*     | in  | [7:0] data_byte                    | byte_valid | end_of_message
// m_*     | out | digest_word0..3 from bit 0 up      | -          | -
//
// Each byte is queued at intake; the 64th byte of a block also loads the
// round registers, then 64 rounds on one shared round unit and a fold add
// the block into the hash while further bytes wait in the queue. An end mark
// pads the open block, adding one more block if it is full or the pad spills.
// Reset (rst_n low, async) restores the initial hash values and zero length.
// A two-entry queue lets intake go on while the round unit works, and the
// digest register holds the result while m_tready is low.
module sha256_stream_hasher
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic [0:0]   s_tuser,   // byte_valid
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // digest_word0, digest_word1, digest_word2, digest_word3
);

    logic           q_valid;
    logic           q_pop;
    sha_pkg::item_t q_item;

    sha_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    sha_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("core popped an empty queue");
    a_digest_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("digest dropped while stalled");
`endif

endmodule

FILE: verif/sha256_digest_checker.sv
`timescale 1ns / 1ps

module sha256_digest_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [255:0] m_tdata,
    output int           fail_count,
    output int           pending_digests
);

    sha_pkg::word_t   hash_state [8];
    sha_pkg::word_t   block_words [16];
    logic [63:0]      bit_count;
    logic [255:0]     digest_queue [$];

    function automatic sha_pkg::word_t ror32(sha_pkg::word_t v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress;
        sha_pkg::word_t v [8];
        sha_pkg::word_t w, s0, s1, t1, t2;
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                w = block_words[t];
            else
            begin
                s1 = ror32(block_words[(t - 2) & 15], 17) ^ ror32(block_words[(t - 2) & 15], 19)
                     ^ (block_words[(t - 2) & 15] >> 10);
                s0 = ror32(block_words[(t - 15) & 15], 7) ^ ror32(block_words[(t - 15) & 15], 18)
                     ^ (block_words[(t - 15) & 15] >> 3);
                w = s1 + block_words[(t - 7) & 15] + s0 + block_words[t & 15];
                block_words[t & 15] = w;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[t] + w;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endtask

    task automatic place_byte(int pos, logic [7:0] b);
        if (pos % 4 == 0)
            block_words[pos / 4] = {b, 24'h0};
        else
            block_words[pos / 4] |= sha_pkg::word_t'(b) << ((3 - pos % 4) * 8);
    endtask

    task automatic absorb_beat(logic [7:0] b, logic vld, logic eom);
        int pos;
        logic [63:0]  len;
        logic [255:0] dig;
        if (vld)
        begin
            pos = int'(bit_count[8:3]);
            place_byte(pos, b);
            bit_count += 64'd8;
            if (pos == 63)
                compress();
        end
        if (eom)
        begin
            len = bit_count;
            pos = int'(len[8:3]);
            place_byte(pos, sha_pkg::PadByte);
            for (int i = pos / 4 + 1; i < 16; i++)
                block_words[i] = '0;
            if (pos >= int'(sha_pkg::LenStartPos))
            begin
                compress();
                for (int i = 0; i < 16; i++)
                    block_words[i] = '0;
            end
            block_words[14] = len[63:32];
            block_words[15] = len[31:0];
            compress();
            // tdata low 64 bits carry digest_word0 = H0:H1
            for (int i = 0; i < 4; i++)
                dig[64 * i +: 64] = {hash_state[2 * i], hash_state[2 * i + 1]};
            digest_queue = {digest_queue, dig};
            for (int i = 0; i < 8; i++)
                hash_state[i] = sha_pkg::InitHash[i];
            bit_count = '0;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending_digests = 0;
        for (int i = 0; i < 8; i++)
            hash_state[i] = sha_pkg::InitHash[i];
        for (int i = 0; i < 16; i++)
            block_words[i] = '0;
        bit_count = '0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (digest_queue.size() == 0)
                begin
                    $display("%0t: unexpected digest: expected none, actual %h", $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    logic [255:0] exp_dig;
                    exp_dig = digest_queue.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (m_tdata[64 * i +: 64] !== exp_dig[64 * i +: 64])
                        begin
                            $display("%0t: digest_word%0d mismatch: expected %h, actual %h",
                                     $time, i, exp_dig[64 * i +: 64], m_tdata[64 * i +: 64]);
                            fail_count++;
                        end
                end
            end
            if (s_tvalid && s_tready)
                absorb_beat(s_tdata, s_tuser[0], s_tlast);
            pending_digests = digest_queue.size();
        end
    end
endmodule

FILE: verif/sha256_stream_hasher_tb.sv
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;
    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic [0:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [255:0] m_tdata;
    int           fail_count;
    int           pending_digests;
    int           cycle_count;
    bit           stim_done;

    localparam int CycleLimit = 2000000;

    sha256_stream_hasher dut (.*);

    sha256_digest_checker checker_i (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // sink: random stall per beat
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int gap;
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_beat(logic [7:0] b, logic vld, logic eom, bit quiet);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= vld;
        s_tlast  <= eom;
        do @(posedge clk); while (!s_tready);
    endtask

    // message of len bytes, with a few idle beats mixed in
    task automatic send_message(int len, bit end_with_byte, bit quiet);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0, quiet);
            send_beat(8'($urandom), 1'b1, end_with_byte && i == len - 1, quiet);
        end
        if (!end_with_byte || len == 0)
            send_beat(8'($urandom), 1'b0, 1'b1, quiet);
    endtask

    initial
    begin
        int sent;
        int len;
        bit quiet;
        stim_done = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        s_tlast  = 1'b0;
        rst_n    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, extreme bytes, idle beats, pad boundaries
        send_beat(8'h00, 1'b0, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0, 1'b0);
        send_beat(8'hff, 1'b1, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0, 1'b0);
        send_beat(8'hff, 1'b0, 1'b1, 1'b0);
        send_beat(8'haa, 1'b1, 1'b0, 1'b0);
        send_beat(8'h55, 1'b1, 1'b1, 1'b0);
        send_message(55, 1'b1, 1'b0);
        send_message(56, 1'b0, 1'b0);
        send_message(63, 1'b1, 1'b0);
        send_message(64, 1'b0, 1'b0);
        send_message(65, 1'b1, 1'b0);
        send_message(119, 1'b0, 1'b0);
        send_message(128, 1'b1, 1'b0);

        sent = 0;
        while (sent < 1400)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 70);
            quiet = ($urandom_range(0, 5) == 0);
            send_message(len, 1'($urandom_range(0, 1)), quiet);
            sent += len + 1;
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CycleLimit)
            begin
                $display("== FAIL ==");
                $finish;
            end
            if (stim_done && pending_digests == 0)
            begin
                repeat (300) @(posedge clk);
                if (fail_count == 0 && pending_digests == 0)
                    $display("== PASS ==");
                else
                    $display("== FAIL ==");
                $finish;
            end
        end
    end
endmodule
